>>> rtl/core/lse_pkg.sv
// Shared types and constants for the list store engine.
package lse_pkg;
   localparam int CAPACITY_DEF   = 256;
   localparam int DATA_WIDTH_DEF = 32;

   typedef enum logic [3:0] {
      CMD_PUSH    = 4'd0,
      CMD_POP     = 4'd1,
      CMD_INSERT  = 4'd2,
      CMD_CLEAR   = 4'd3,
      CMD_ERASE   = 4'd4,
      CMD_READ    = 4'd5,
      CMD_WRITE   = 4'd6,
      CMD_COUNT   = 4'd7,
      CMD_REMOVE  = 4'd8,
      CMD_SORT    = 4'd9,
      CMD_REVERSE = 4'd10
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_BAD   = 2'd3
   } status_type;

   // datapath commands issued by the controller each cycle
   typedef struct packed {
      logic       rd_en;      // read element at rd_addr
      logic       wr_en;      // write wr_sel data at wr_addr
      logic [1:0] wr_sel;     // 0 value, 1 read data, 2 held word
      logic       hold_load;  // capture read data into held word
      logic       cnt_clear;  // zero the match counter
      logic       cmp_take;   // compare read data with value, bump counter on match
      logic       data_take;  // latch read data as result data
      logic       val_load;   // capture the request value
   } dp_cmd_type;

   localparam logic [1:0] WSEL_VALUE = 2'd0;
   localparam logic [1:0] WSEL_RDATA = 2'd1;
   localparam logic [1:0] WSEL_HOLD  = 2'd2;
endpackage

>>> rtl/core/list_store_engine.sv
// Top level of the list store engine.
// A fixed-capacity list of signed words driven by one command per beat. Raise start with
// the request fields; the beat is taken on the edge where busy is low, after which the
// fields may change. Every command gives exactly one result: rsp_valid is high for one
// cycle and the receiver cannot stall it. busy falls in the result cycle, so the next
// command can be taken in that same cycle. A refused command, clear or an unknown code
// goes straight to the result, as do count, remove, sort and reverse on a list too short
// to walk; push and write write one element; pop and read read one element; count compares
// every element with the value, remove compares up to the first match and then moves the
// later elements down; insert and erase move the elements behind the index; reverse swaps
// pairs from both ends; sort runs an insertion sort.
module list_store_engine #(
   parameter int CAPACITY   = lse_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = lse_pkg::DATA_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [3:0]   req_command,
   input  logic [7:0]   req_index,
   input  logic [7:0]   req_end_index,
   input  logic [31:0]  req_value,
   input  logic         req_descending,
   output logic         rsp_valid,
   output logic [31:0]  rsp_data,
   output logic [8:0]   rsp_match_count,
   output logic [8:0]   rsp_length,
   output logic [1:0]   rsp_status
);
   import lse_pkg::*;
   localparam int AW = $clog2(CAPACITY);

   dp_cmd_type            dp_cmd;
   logic [AW-1:0]         rd_addr, wr_addr;
   logic [DATA_WIDTH-1:0] value_ext, rd_data, hold_data, res_data;
   logic                  match, done, use_cnt, use_data;
   logic [AW:0]           match_cnt, length;
   status_type            status;

   assign value_ext = DATA_WIDTH'($signed(req_value));

   lse_ctrl #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_command    (req_command),
      .req_index      (req_index),
      .req_end_index  (req_end_index),
      .req_descending (req_descending),
      .busy           (busy),
      .cmd            (dp_cmd),
      .rd_addr        (rd_addr),
      .wr_addr        (wr_addr),
      .rd_data        (rd_data),
      .hold_data      (hold_data),
      .match          (match),
      .done           (done),
      .use_cnt        (use_cnt),
      .use_data       (use_data),
      .length         (length),
      .status         (status)
   );

   lse_datapath #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_datapath (
      .clock     (clock),
      .cmd       (dp_cmd),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .value     (value_ext),
      .rd_data   (rd_data),
      .hold_data (hold_data),
      .match     (match),
      .match_cnt (match_cnt),
      .res_data  (res_data)
   );

   assign rsp_valid       = done;
   assign rsp_data        = use_data ? 32'($signed(res_data)) : '0;
   assign rsp_match_count = use_cnt ? 9'(match_cnt) : '0;
   assign rsp_length      = 9'(length);
   assign rsp_status      = status;
endmodule

>>> rtl/core/lse_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module lse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/core/lse_datapath.sv
// Element store, held word, match counter and result data register.
module lse_datapath #(
   parameter int CAPACITY   = lse_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = lse_pkg::DATA_WIDTH_DEF
) (
   input  logic                        clock,
   input  lse_pkg::dp_cmd_type         cmd,
   input  logic [$clog2(CAPACITY)-1:0] rd_addr,
   input  logic [$clog2(CAPACITY)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]       value,
   output logic [DATA_WIDTH-1:0]       rd_data,
   output logic [DATA_WIDTH-1:0]       hold_data,
   output logic                        match,
   output logic [$clog2(CAPACITY):0]   match_cnt,
   output logic [DATA_WIDTH-1:0]       res_data
);
   import lse_pkg::*;
   localparam int AW = $clog2(CAPACITY);

   logic [DATA_WIDTH-1:0] wr_data;
   logic [DATA_WIDTH-1:0] hold_ff;
   logic [DATA_WIDTH-1:0] val_ff;
   logic [DATA_WIDTH-1:0] res_data_ff;
   logic [AW:0]           cnt_ff;

   always_comb begin
      case (cmd.wr_sel)
         WSEL_RDATA: wr_data = rd_data;
         WSEL_HOLD:  wr_data = hold_ff;
         default:    wr_data = val_ff;
      endcase
   end

   lse_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign match = (rd_data == val_ff);

   always_ff @(posedge clock) begin
      if (cmd.val_load) val_ff <= value;
      if (cmd.hold_load) hold_ff <= rd_data;
      if (cmd.cnt_clear) cnt_ff <= '0;
      else if (cmd.cmp_take && match) cnt_ff <= cnt_ff + 1'b1;
      if (cmd.data_take) res_data_ff <= rd_data;
   end

   assign hold_data = hold_ff;
   assign match_cnt = cnt_ff;
   assign res_data  = res_data_ff;
endmodule

>>> rtl/core/lse_ctrl.sv
// Command sequencer: checks, walks the store and builds each result.
module lse_ctrl #(
   parameter int CAPACITY   = lse_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = lse_pkg::DATA_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [3:0]                  req_command,
   input  logic [7:0]                  req_index,
   input  logic [7:0]                  req_end_index,
   input  logic                        req_descending,
   output logic                        busy,
   output lse_pkg::dp_cmd_type         cmd,
   output logic [$clog2(CAPACITY)-1:0] rd_addr,
   output logic [$clog2(CAPACITY)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]       rd_data,
   input  logic [DATA_WIDTH-1:0]       hold_data,
   input  logic                        match,
   output logic                        done,
   output logic                        use_cnt,
   output logic                        use_data,
   output logic [$clog2(CAPACITY):0]   length,
   output lse_pkg::status_type         status
);
   import lse_pkg::*;
   localparam int AW = $clog2(CAPACITY);
   localparam int LW = (AW + 1 > 9) ? AW + 1 : 9;
   localparam logic [LW-1:0] CAP = LW'(CAPACITY);
   localparam logic [LW-1:0] ONE = LW'(1);
   localparam logic [LW-1:0] TWO = LW'(2);

   typedef enum logic [3:0] {
      S_IDLE, S_PUT, S_RD, S_WAIT, S_SHIFT, S_SCAN, S_REV_A, S_REV_B, S_REV_C,
      S_SORT_KEY, S_SORT_RD, S_SORT_CMP, S_SORT_FIN, S_DONE
   } state_type;

   state_type     state_ff;
   cmd_type       op_ff;
   logic [LW-1:0] len_ff;
   logic [LW-1:0] i_ff;      // primary walk pointer
   logic [LW-1:0] j_ff;      // secondary pointer / bound
   logic [LW-1:0] k_ff;      // shift distance
   logic          desc_ff;
   logic          use_cnt_ff, use_data_ff, done_ff;
   status_type    status_ff;
   logic [AW-1:0] rd_addr_in, wr_addr_in;
   dp_cmd_type    cmd_in;

   logic [LW-1:0] idx_w, end_w;
   assign idx_w = LW'(req_index);
   assign end_w = LW'(req_end_index);

   // signed order: does held word go before read data
   logic hold_first;
   always_comb begin
      if (desc_ff) hold_first = $signed(hold_data) > $signed(rd_data);
      else         hold_first = $signed(hold_data) < $signed(rd_data);
   end

   assign cmd      = cmd_in;
   assign rd_addr  = rd_addr_in;
   assign wr_addr  = wr_addr_in;

   // datapath commands are combinational from state, start and the sort comparison
   always_comb begin
      cmd_in     = '0;
      rd_addr_in = '0;
      wr_addr_in = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in.cnt_clear = 1'b1;
               cmd_in.val_load  = 1'b1;
            end
         end
         S_PUT: begin
            cmd_in.wr_en  = 1'b1;
            cmd_in.wr_sel = WSEL_VALUE;
            wr_addr_in    = j_ff[AW-1:0];
         end
         S_RD: begin
            cmd_in.rd_en = 1'b1;
            rd_addr_in   = i_ff[AW-1:0];
         end
         S_WAIT: begin
            cmd_in.data_take = 1'b1;
         end
         S_SHIFT: begin
            // insert moves i up to i+1 walking down, erase moves i down by k walking up
            cmd_in.wr_en  = 1'b1;
            cmd_in.wr_sel = WSEL_RDATA;
            wr_addr_in    = (op_ff == CMD_INSERT) ? AW'(i_ff + ONE) : AW'(i_ff - k_ff);
         end
         S_SCAN: begin
            cmd_in.cmp_take = 1'b1;
         end
         S_REV_A: begin
            cmd_in.rd_en     = 1'b1;
            cmd_in.hold_load = 1'b1;
            rd_addr_in       = j_ff[AW-1:0];
         end
         S_REV_B: begin
            cmd_in.wr_en  = 1'b1;
            cmd_in.wr_sel = WSEL_RDATA;
            wr_addr_in    = i_ff[AW-1:0];
         end
         S_REV_C: begin
            cmd_in.wr_en  = 1'b1;
            cmd_in.wr_sel = WSEL_HOLD;
            wr_addr_in    = j_ff[AW-1:0];
         end
         S_SORT_KEY: begin
            cmd_in.hold_load = 1'b1;
            cmd_in.rd_en     = 1'b1;
            rd_addr_in       = AW'(i_ff - ONE);
         end
         S_SORT_RD: begin
            cmd_in.rd_en = 1'b1;
            rd_addr_in   = AW'(j_ff - ONE);
         end
         S_SORT_CMP: begin
            if (hold_first) begin
               cmd_in.wr_en  = 1'b1;
               cmd_in.wr_sel = WSEL_RDATA;
               wr_addr_in    = j_ff[AW-1:0];
            end
         end
         S_SORT_FIN: begin
            cmd_in.wr_en  = 1'b1;
            cmd_in.wr_sel = WSEL_HOLD;
            wr_addr_in    = j_ff[AW-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         len_ff      <= '0;
         done_ff     <= 1'b0;
         use_cnt_ff  <= 1'b0;
         use_data_ff <= 1'b0;
         status_ff   <= ST_OK;
         op_ff       <= CMD_PUSH;
         i_ff        <= '0;
         j_ff        <= '0;
         k_ff        <= '0;
         desc_ff     <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (start) begin
               op_ff       <= cmd_type'(req_command);
               desc_ff     <= req_descending;
               status_ff   <= ST_OK;
               use_cnt_ff  <= 1'b0;
               use_data_ff <= 1'b0;
               state_ff    <= S_DONE;
               unique case (req_command)
                  CMD_PUSH:
                     if (len_ff >= CAP) status_ff <= ST_FULL;
                     else begin
                        j_ff     <= len_ff;
                        len_ff   <= len_ff + ONE;
                        state_ff <= S_PUT;
                     end
                  CMD_POP:
                     if (len_ff == '0) status_ff <= ST_EMPTY;
                     else begin
                        len_ff      <= len_ff - ONE;
                        i_ff        <= len_ff - ONE;
                        use_data_ff <= 1'b1;
                        state_ff    <= S_RD;
                     end
                  CMD_INSERT:
                     if (len_ff >= CAP) status_ff <= ST_FULL;
                     else if (idx_w > len_ff) status_ff <= ST_BAD;
                     else begin
                        j_ff   <= idx_w;
                        len_ff <= len_ff + ONE;
                        if (len_ff == idx_w) state_ff <= S_PUT;
                        else begin
                           i_ff     <= len_ff - ONE;
                           state_ff <= S_RD;
                        end
                     end
                  CMD_CLEAR: len_ff <= '0;
                  CMD_ERASE:
                     if (idx_w > end_w || end_w >= len_ff) status_ff <= ST_BAD;
                     else begin
                        k_ff   <= end_w - idx_w + ONE;
                        i_ff   <= end_w + ONE;
                        j_ff   <= len_ff;
                        len_ff <= len_ff - (end_w - idx_w + ONE);
                        if (end_w + ONE != len_ff) state_ff <= S_RD;
                     end
                  CMD_READ:
                     if (idx_w >= len_ff) status_ff <= ST_BAD;
                     else begin
                        i_ff        <= idx_w;
                        use_data_ff <= 1'b1;
                        state_ff    <= S_RD;
                     end
                  CMD_WRITE:
                     if (idx_w >= len_ff) status_ff <= ST_BAD;
                     else begin
                        j_ff     <= idx_w;
                        state_ff <= S_PUT;
                     end
                  CMD_COUNT, CMD_REMOVE: begin
                     use_cnt_ff <= 1'b1;
                     i_ff       <= '0;
                     if (len_ff != '0) state_ff <= S_RD;
                  end
                  CMD_SORT:
                     if (len_ff > ONE) begin
                        i_ff     <= ONE;
                        state_ff <= S_RD;
                     end
                  CMD_REVERSE:
                     if (len_ff > ONE) begin
                        i_ff     <= '0;
                        j_ff     <= len_ff - ONE;
                        state_ff <= S_RD;
                     end
                  default: ;
               endcase
            end
            S_PUT: state_ff <= S_DONE;
            S_RD: begin
               unique case (op_ff)
                  CMD_INSERT, CMD_ERASE: state_ff <= S_SHIFT;
                  CMD_COUNT, CMD_REMOVE: state_ff <= S_SCAN;
                  CMD_SORT:              state_ff <= S_SORT_KEY;
                  CMD_REVERSE:           state_ff <= S_REV_A;
                  default:               state_ff <= S_WAIT;
               endcase
            end
            S_WAIT: state_ff <= S_DONE;
            S_SHIFT: begin
               if (op_ff == CMD_INSERT) begin
                  if (i_ff == j_ff) state_ff <= S_PUT;
                  else begin
                     i_ff     <= i_ff - ONE;
                     state_ff <= S_RD;
                  end
               end else begin
                  if (i_ff + ONE == j_ff) state_ff <= S_DONE;
                  else begin
                     i_ff     <= i_ff + ONE;
                     state_ff <= S_RD;
                  end
               end
            end
            S_SCAN: begin
               if (op_ff == CMD_REMOVE && match) begin
                  // drop the matched word: continue as an erase of one element
                  op_ff  <= CMD_ERASE;
                  k_ff   <= ONE;
                  j_ff   <= len_ff;
                  len_ff <= len_ff - ONE;
                  if (i_ff + ONE == len_ff) state_ff <= S_DONE;
                  else begin
                     i_ff     <= i_ff + ONE;
                     state_ff <= S_RD;
                  end
               end else if (i_ff + ONE == len_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  i_ff     <= i_ff + ONE;
                  state_ff <= S_RD;
               end
            end
            S_REV_A: state_ff <= S_REV_B;
            S_REV_B: state_ff <= S_REV_C;
            S_REV_C: begin
               if (i_ff + TWO >= j_ff) state_ff <= S_DONE;
               else begin
                  i_ff     <= i_ff + ONE;
                  j_ff     <= j_ff - ONE;
                  state_ff <= S_RD;
               end
            end
            S_SORT_KEY: begin
               // hold = key; walk j down from i
               j_ff     <= i_ff;
               state_ff <= S_SORT_CMP;
            end
            S_SORT_RD: state_ff <= S_SORT_CMP;
            S_SORT_CMP: begin
               if (hold_first) begin
                  j_ff <= j_ff - ONE;
                  if (j_ff == ONE) state_ff <= S_SORT_FIN;
                  else state_ff <= S_SORT_RD;
               end else state_ff <= S_SORT_FIN;
            end
            S_SORT_FIN: begin
               if (i_ff + ONE >= len_ff) state_ff <= S_DONE;
               else begin
                  i_ff     <= i_ff + ONE;
                  state_ff <= S_RD;
               end
            end
            S_DONE: begin
               done_ff  <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy     = (state_ff != S_IDLE);
   assign done     = done_ff;
   assign use_cnt  = use_cnt_ff;
   assign use_data = use_data_ff;
   assign length   = len_ff[AW:0];
   assign status   = status_ff;

   a_done_single: assert property (@(posedge clock) disable iff (reset) done |=> !done);
   a_done_idle: assert property (@(posedge clock) disable iff (reset) done |-> !busy);
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy);
   a_len_bound: assert property (@(posedge clock) disable iff (reset) len_ff <= CAP);
endmodule

>>> bench/list_store_checker.sv
// Checker for the list store engine: predicts each command's result and compares.
module list_store_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [3:0]  req_command,
   input  logic [7:0]  req_index,
   input  logic [7:0]  req_end_index,
   input  logic [31:0] req_value,
   input  logic        req_descending,
   input  logic        rsp_valid,
   input  logic [31:0] rsp_data,
   input  logic [8:0]  rsp_match_count,
   input  logic [8:0]  rsp_length,
   input  logic [1:0]  rsp_status,
   output int          fail_count,
   output int          pending_count
);
   import lse_pkg::*;

   typedef struct packed {
      logic [31:0] data;
      logic [8:0]  match_count;
      logic [8:0]  length;
      status_type  status;
   } list_result_t;

   localparam int DEPTH = CAPACITY_DEF;

   logic signed [31:0] elems [DEPTH];
   int                 elem_len;
   list_result_t       expected_q [$];

   // Apply one command to the shadow list and return its result.
   function automatic list_result_t apply_command(input logic [3:0] cmd,
         input int idx, input int last, input logic signed [31:0] val,
         input logic desc);
      list_result_t       res;
      logic signed [31:0] x;
      int                 i;
      int                 j;
      int                 gap;
      res = '0;
      res.status = ST_OK;
      case (cmd)
         CMD_PUSH: begin
            if (elem_len >= DEPTH) res.status = ST_FULL;
            else begin
               elems[elem_len] = val;
               elem_len++;
            end
         end
         CMD_POP: begin
            if (elem_len == 0) res.status = ST_EMPTY;
            else begin
               elem_len--;
               res.data = elems[elem_len];
            end
         end
         CMD_INSERT: begin
            if (elem_len >= DEPTH) res.status = ST_FULL;
            else if (idx > elem_len) res.status = ST_BAD;
            else begin
               for (i = elem_len; i > idx; i--) elems[i] = elems[i-1];
               elems[idx] = val;
               elem_len++;
            end
         end
         CMD_CLEAR: elem_len = 0;
         CMD_ERASE: begin
            if (idx > last || last >= elem_len) res.status = ST_BAD;
            else begin
               gap = last - idx + 1;
               for (i = last + 1; i < elem_len; i++) elems[i-gap] = elems[i];
               elem_len -= gap;
            end
         end
         CMD_READ: begin
            if (idx >= elem_len) res.status = ST_BAD;
            else res.data = elems[idx];
         end
         CMD_WRITE: begin
            if (idx >= elem_len) res.status = ST_BAD;
            else elems[idx] = val;
         end
         CMD_COUNT: begin
            for (i = 0; i < elem_len; i++)
               if (elems[i] == val) res.match_count++;
         end
         CMD_REMOVE: begin
            for (i = 0; i < elem_len; i++) begin
               if (elems[i] == val) begin
                  for (j = i; j + 1 < elem_len; j++) elems[j] = elems[j+1];
                  elem_len--;
                  res.match_count = 1;
                  break;
               end
            end
         end
         CMD_SORT: begin
            for (i = 1; i < elem_len; i++) begin
               x = elems[i];
               j = i;
               while (j > 0 && (desc ? (x > elems[j-1]) : (x < elems[j-1]))) begin
                  elems[j] = elems[j-1];
                  j--;
               end
               elems[j] = x;
            end
         end
         CMD_REVERSE: begin
            for (i = 0; i < elem_len / 2; i++) begin
               x = elems[elem_len-1-i];
               elems[elem_len-1-i] = elems[i];
               elems[i] = x;
            end
         end
         default: ;
      endcase
      res.length = elem_len[8:0];
      return res;
   endfunction

   always @(posedge clock) begin
      list_result_t want;
      if (reset) begin
         elem_len = 0;
         expected_q.delete();
      end else begin
         if (start && !busy)
            expected_q.push_back(apply_command(req_command, int'(req_index),
               int'(req_end_index), $signed(req_value), req_descending));
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result beat data=%h len=%0d", $time,
                  rsp_data, rsp_length);
            end else begin
               want = expected_q.pop_front();
               if (rsp_data !== want.data) begin
                  fail_count++;
                  $display("%0t: data expected %h actual %h", $time, want.data,
                     rsp_data);
               end
               if (rsp_match_count !== want.match_count) begin
                  fail_count++;
                  $display("%0t: match_count expected %0d actual %0d", $time,
                     want.match_count, rsp_match_count);
               end
               if (rsp_length !== want.length) begin
                  fail_count++;
                  $display("%0t: length expected %0d actual %0d", $time,
                     want.length, rsp_length);
               end
               if (rsp_status !== want.status) begin
                  fail_count++;
                  $display("%0t: status expected %0d actual %0d", $time,
                     want.status, rsp_status);
               end
            end
         end
      end
      pending_count <= expected_q.size();
   end
endmodule

>>> bench/tb_top.sv
// Testbench top for the list store engine: stimulus and verdict.
module tb_top;
   import lse_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [3:0]  req_command = '0;
   logic [7:0]  req_index = '0;
   logic [7:0]  req_end_index = '0;
   logic [31:0] req_value = '0;
   logic        req_descending = 0;
   logic        rsp_valid;
   logic [31:0] rsp_data;
   logic [8:0]  rsp_match_count;
   logic [8:0]  rsp_length;
   logic [1:0]  rsp_status;
   int          fail_count;
   int          pending_count;
   int          list_len = 0;

   always #5 clock = ~clock;

   list_store_engine DUT (.*);
   list_store_checker u_checker (.*);

   // track the length the block reports, to steer the stimulus
   always @(posedge clock) if (rsp_valid) list_len <= int'(rsp_length);

   initial begin
      #400_000_000;
      $display("list_store_engine verification failed");
      $finish;
   end

   task automatic send_beat(input logic [3:0] cmd, input int idx, input int last,
         input logic [31:0] val, input logic desc);
      int   gap;
      logic taken;
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1;
      req_command    <= cmd;
      req_index      <= idx[7:0];
      req_end_index  <= last[7:0];
      req_value      <= val;
      req_descending <= desc;
      // sample busy mid-cycle so the coming edge is known to take the beat
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom();
         default: return 32'($signed($urandom_range(0, 6)) - 3);
      endcase
   endfunction

   function automatic int pick_index();
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 255);
      return $urandom_range(0, list_len);
   endfunction

   initial begin
      int        i;
      int        r;
      int        idx;
      logic [3:0] cmd;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // empty-list corner cases, then a short list
      send_beat(CMD_POP, 0, 0, 0, 0);
      send_beat(CMD_READ, 0, 0, 0, 0);
      send_beat(CMD_ERASE, 0, 0, 0, 0);
      send_beat(CMD_COUNT, 0, 0, 0, 0);
      send_beat(CMD_PUSH, 0, 0, 32'h8000_0000, 0);
      send_beat(CMD_PUSH, 0, 0, 32'h7fff_ffff, 0);
      send_beat(CMD_PUSH, 0, 0, 32'hffff_ffff, 0);
      send_beat(CMD_INSERT, 0, 0, 32'd5, 0);
      send_beat(CMD_INSERT, 4, 0, 32'd0, 0);
      send_beat(CMD_INSERT, 9, 0, 32'd1, 0);
      send_beat(CMD_READ, 2, 0, 0, 0);
      send_beat(CMD_WRITE, 1, 0, 32'hffff_ffff, 0);
      send_beat(CMD_WRITE, 255, 0, 32'd3, 0);
      send_beat(CMD_COUNT, 0, 0, 32'hffff_ffff, 0);
      send_beat(CMD_REMOVE, 0, 0, 32'hffff_ffff, 0);
      send_beat(CMD_REMOVE, 0, 0, 32'd77, 0);
      send_beat(CMD_SORT, 0, 0, 0, 0);
      send_beat(CMD_SORT, 0, 0, 0, 1);
      send_beat(CMD_REVERSE, 0, 0, 0, 0);
      send_beat(CMD_ERASE, 2, 1, 0, 0);
      send_beat(CMD_ERASE, 1, 2, 0, 0);
      send_beat(4'd11, 0, 0, 0, 0);
      send_beat(4'd15, 255, 255, 32'hffff_ffff, 1);
      send_beat(CMD_CLEAR, 0, 0, 0, 0);
      // fill to capacity, then exercise the full list
      for (i = 0; i < CAPACITY_DEF; i++) send_beat(CMD_PUSH, 0, 0, pick_value(), 0);
      send_beat(CMD_PUSH, 0, 0, 32'd1, 0);
      send_beat(CMD_INSERT, 300, 0, 32'd1, 0);
      send_beat(CMD_SORT, 0, 0, 0, 1);
      send_beat(CMD_READ, 255, 0, 0, 0);
      send_beat(CMD_REVERSE, 0, 0, 0, 0);
      send_beat(CMD_COUNT, 0, 0, 32'd0, 0);
      send_beat(CMD_ERASE, 1, 255, 0, 0);
      send_beat(CMD_POP, 0, 0, 0, 0);
      // hold off until the block has drained
      start <= 0;
      while (pending_count != 0 || busy) @(posedge clock);
      for (i = 0; i < 660; i++) begin
         r = $urandom_range(0, 99);
         idx = pick_index();
         if (r < (list_len < 24 ? 32 : 14)) cmd = CMD_PUSH;
         else if (r < 40) cmd = CMD_POP;
         else if (r < 50) cmd = CMD_INSERT;
         else if (r < 58) cmd = CMD_READ;
         else if (r < 66) cmd = CMD_WRITE;
         else if (r < 73) cmd = CMD_COUNT;
         else if (r < 80) cmd = CMD_REMOVE;
         else if (r < 87) cmd = CMD_ERASE;
         else if (r < 92) cmd = CMD_SORT;
         else if (r < 96) cmd = CMD_REVERSE;
         else if (r < 98) cmd = CMD_CLEAR;
         else cmd = 4'($urandom_range(11, 15));
         if (cmd == CMD_ERASE && $urandom_range(0, 4) != 0)
            send_beat(cmd, idx, idx + $urandom_range(0, 3), pick_value(),
               1'($urandom_range(0, 1)));
         else
            send_beat(cmd, idx, $urandom_range(0, 255), pick_value(),
               1'($urandom_range(0, 1)));
      end
      start <= 0;
      while (pending_count != 0 || busy) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("list_store_engine verification clean");
      else
         $display("list_store_engine verification failed");
      $finish;
   end
endmodule
